### rtl/cde_pkg.sv
// Shared types for the circular deque engine: request codes, status codes,
// the decoded word passed from the front end to the back end, and results.
// No dependencies.
`timescale 1ns / 1ps

package cde_pkg;

    // Raw request codes as they arrive on the action port
    typedef enum logic [2:0] {
        ACT_PUSH_LEFT  = 3'd0,
        ACT_PUSH_RIGHT = 3'd1,
        ACT_POP_LEFT   = 3'd2,
        ACT_POP_RIGHT  = 3'd3,
        ACT_PEEK_LEFT  = 3'd4,
        ACT_PEEK_RIGHT = 3'd5,
        ACT_SEARCH     = 3'd6,
        ACT_CLEAR      = 3'd7
    } action_t;

    // Operation class after decode
    typedef enum logic [2:0] {
        OP_PUSH   = 3'd0,
        OP_POP    = 3'd1,
        OP_PEEK   = 3'd2,
        OP_SEARCH = 3'd3,
        OP_CLEAR  = 3'd4
    } op_kind_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        BK_IDLE   = 2'd0,
        BK_READ   = 2'd1,
        BK_SEARCH = 2'd2
    } back_state_t;

    localparam int WORD_W   = 32;
    localparam int CNT_W    = 7;
    localparam int POS_W    = 6;
    localparam int QUEUE_DEPTH = 2;

    // Decoded request word
    typedef struct packed {
        op_kind_t            kind;
        logic                left_end;
        logic [WORD_W-1:0]   data;
    } op_t;

    // One result word
    typedef struct packed {
        logic [WORD_W-1:0]   data;
        status_t             status;
        logic [POS_W-1:0]    pos;
        logic [CNT_W-1:0]    count;
        logic                empty;
        logic                full;
    } result_t;

    // Assemble a result, deriving the flags from the count after the request
    function automatic result_t make_result(
        input logic [WORD_W-1:0] data,
        input status_t           status,
        input logic [POS_W-1:0]  pos,
        input logic [CNT_W-1:0]  count,
        input logic [CNT_W-1:0]  cap
    );
        result_t r;
        r.data   = data;
        r.status = status;
        r.pos    = pos;
        r.count  = count;
        r.empty  = (count == '0);
        r.full   = (count >= cap);
        return r;
    endfunction

endpackage

### rtl/cde_front.sv
// Front end of the deque engine: input handshake and request decode.
// Depends on cde_pkg; feeds cde_queue.
`timescale 1ns / 1ps

module cde_front (
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [2:0]                    action,
    input  logic signed [31:0]            data_in,
    input  logic                          q_full,
    output logic                          q_push,
    output cde_pkg::op_t                  q_op
);

    // Stall only when the queue has no room
    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    // Classify the request into an operation and the end it works on
    always_comb
    begin
        q_op.data     = data_in;
        q_op.kind     = cde_pkg::OP_CLEAR;
        q_op.left_end = 1'b0;
        case (cde_pkg::action_t'(action))
            cde_pkg::ACT_PUSH_LEFT:
            begin
                q_op.kind     = cde_pkg::OP_PUSH;
                q_op.left_end = 1'b1;
            end
            cde_pkg::ACT_PUSH_RIGHT: q_op.kind = cde_pkg::OP_PUSH;
            cde_pkg::ACT_POP_LEFT:
            begin
                q_op.kind     = cde_pkg::OP_POP;
                q_op.left_end = 1'b1;
            end
            cde_pkg::ACT_POP_RIGHT:  q_op.kind = cde_pkg::OP_POP;
            cde_pkg::ACT_PEEK_LEFT:
            begin
                q_op.kind     = cde_pkg::OP_PEEK;
                q_op.left_end = 1'b1;
            end
            cde_pkg::ACT_PEEK_RIGHT: q_op.kind = cde_pkg::OP_PEEK;
            cde_pkg::ACT_SEARCH:     q_op.kind = cde_pkg::OP_SEARCH;
            cde_pkg::ACT_CLEAR:      q_op.kind = cde_pkg::OP_CLEAR;
            default:                 q_op.kind = cde_pkg::OP_CLEAR;
        endcase
    end

endmodule

### rtl/cde_queue.sv
// Two-entry queue of decoded request words between front and back end.
// Depends on cde_pkg.
`timescale 1ns / 1ps

module cde_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  cde_pkg::op_t  op_in,
    output logic          full,
    output logic          valid,
    input  logic          pop,
    output cde_pkg::op_t  op_out
);

    localparam int PTR_W  = (cde_pkg::QUEUE_DEPTH > 1) ? $clog2(cde_pkg::QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(cde_pkg::QUEUE_DEPTH + 1);

    cde_pkg::op_t        entry_reg [cde_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic                do_push, do_pop;

    assign full    = (fill_reg == FILL_W'(cde_pkg::QUEUE_DEPTH));
    assign valid   = (fill_reg != '0);
    assign op_out  = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(cde_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(cde_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Entry storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= op_in;
        end
    end

endmodule

### rtl/cde_back.sv
// Back end of the deque engine: ring store, end indices, count, capacity,
// search sequencer and the registered result word. Depends on cde_pkg.
`timescale 1ns / 1ps

module cde_back #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [6:0]            cfg_wr_data,
    input  logic                  q_valid,
    input  cde_pkg::op_t          q_op,
    output logic                  q_pop,
    output logic                  out_valid,
    input  logic                  out_stall,
    output cde_pkg::result_t      result
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int MW = ((IW > cde_pkg::CNT_W) ? IW : cde_pkg::CNT_W) + 1;
    localparam logic [cde_pkg::CNT_W-1:0] CAP_RESET =
        cde_pkg::CNT_W'((DEPTH < 64) ? DEPTH : 64);

    // Ring neighbors within the capacity in use
    function automatic logic [IW-1:0] idx_next(input logic [IW-1:0] i,
                                               input logic [cde_pkg::CNT_W-1:0] cap);
        logic [MW-1:0] ie;
        logic [MW-1:0] ce;
        ie = MW'(i);
        ce = MW'(cap);
        return (ie + MW'(1) >= ce) ? '0 : IW'(ie + MW'(1));
    endfunction

    function automatic logic [IW-1:0] idx_prev(input logic [IW-1:0] i,
                                               input logic [cde_pkg::CNT_W-1:0] cap);
        logic [MW-1:0] ie;
        logic [MW-1:0] ce;
        ie = MW'(i);
        ce = MW'(cap);
        return (ie == '0 || ie > ce) ? IW'(ce - MW'(1)) : IW'(ie - MW'(1));
    endfunction

    // Ring store
    logic [DATA_WIDTH-1:0]           mem [DEPTH];
    logic [DATA_WIDTH-1:0]           rd_data_reg;
    logic                            rd_en, wr_en;
    logic [IW-1:0]                   rd_addr, wr_addr;

    cde_pkg::back_state_t            state_reg, state_next;
    logic [IW-1:0]                   left_reg, left_next;
    logic [IW-1:0]                   right_reg, right_next;
    logic [cde_pkg::CNT_W-1:0]       count_reg, count_next;
    logic [cde_pkg::CNT_W-1:0]       cap_reg, cap_cfg;
    logic [DATA_WIDTH-1:0]           key_reg, key_next;
    logic [IW-1:0]                   addr_reg, addr_next;
    logic [cde_pkg::CNT_W-1:0]       pos_reg, pos_next;
    logic                            out_valid_reg;
    cde_pkg::result_t                res_reg, res_next;
    logic                            load_out;

    logic                            slot_free, take, is_empty, is_full;
    logic                            hit, last, search_done;
    logic [63:0]                     op_data64, rd_data64;
    logic [DATA_WIDTH-1:0]           op_word;
    logic [cde_pkg::WORD_W-1:0]      rd_word32;

    // Word width conversions
    assign op_data64 = {32'b0, q_op.data};
    assign op_word   = op_data64[DATA_WIDTH-1:0];
    assign rd_data64 = 64'(rd_data_reg);
    assign rd_word32 = rd_data64[cde_pkg::WORD_W-1:0];

    // Shared conditions
    assign slot_free   = !out_valid_reg || !out_stall;
    assign take        = (state_reg == cde_pkg::BK_IDLE) && q_valid && slot_free;
    assign q_pop       = take;
    assign is_empty    = (count_reg == '0);
    assign is_full     = (count_reg >= cap_reg);
    assign hit         = (rd_data_reg == key_reg);
    assign last        = ((MW'(pos_reg) + MW'(1)) == MW'(count_reg));
    assign search_done = hit || last;

    // Capacity write: zero acts as one, above the store depth acts as the depth
    always_comb
    begin
        if (cfg_wr_data == '0)
        begin
            cap_cfg = cde_pkg::CNT_W'(1);
        end
        else if (int'(cfg_wr_data) > DEPTH)
        begin
            cap_cfg = cde_pkg::CNT_W'(DEPTH);
        end
        else
        begin
            cap_cfg = cfg_wr_data;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cde_pkg::BK_IDLE:
            begin
                if (take && !is_empty)
                begin
                    if (q_op.kind == cde_pkg::OP_POP || q_op.kind == cde_pkg::OP_PEEK)
                    begin
                        state_next = cde_pkg::BK_READ;
                    end
                    else if (q_op.kind == cde_pkg::OP_SEARCH)
                    begin
                        state_next = cde_pkg::BK_SEARCH;
                    end
                end
            end
            cde_pkg::BK_READ:
            begin
                if (slot_free)
                begin
                    state_next = cde_pkg::BK_IDLE;
                end
            end
            cde_pkg::BK_SEARCH:
            begin
                if (search_done && slot_free)
                begin
                    state_next = cde_pkg::BK_IDLE;
                end
            end
            default: state_next = cde_pkg::BK_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        left_next  = left_reg;
        right_next = right_reg;
        count_next = count_reg;
        key_next   = key_reg;
        addr_next  = addr_reg;
        pos_next   = pos_reg;
        rd_en      = 1'b0;
        rd_addr    = left_reg;
        wr_en      = 1'b0;
        wr_addr    = right_reg;
        load_out   = 1'b0;
        res_next   = res_reg;
        case (state_reg)
            cde_pkg::BK_IDLE:
            begin
                if (take)
                begin
                    case (q_op.kind)
                        cde_pkg::OP_PUSH:
                        begin
                            load_out = 1'b1;
                            if (is_full)
                            begin
                                res_next = cde_pkg::make_result('0, cde_pkg::ST_FULL, '0,
                                                                count_reg, cap_reg);
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg + 1'b1;
                                if (q_op.left_end)
                                begin
                                    left_next = idx_prev(left_reg, cap_reg);
                                    wr_addr   = left_next;
                                end
                                else
                                begin
                                    wr_addr    = right_reg;
                                    right_next = idx_next(right_reg, cap_reg);
                                end
                                res_next = cde_pkg::make_result('0, cde_pkg::ST_OK, '0,
                                                                count_next, cap_reg);
                            end
                        end
                        cde_pkg::OP_POP:
                        begin
                            if (is_empty)
                            begin
                                load_out = 1'b1;
                                res_next = cde_pkg::make_result('0, cde_pkg::ST_EMPTY, '0,
                                                                count_reg, cap_reg);
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                count_next = count_reg - 1'b1;
                                if (q_op.left_end)
                                begin
                                    rd_addr   = left_reg;
                                    left_next = idx_next(left_reg, cap_reg);
                                end
                                else
                                begin
                                    right_next = idx_prev(right_reg, cap_reg);
                                    rd_addr    = right_next;
                                end
                            end
                        end
                        cde_pkg::OP_PEEK:
                        begin
                            if (is_empty)
                            begin
                                load_out = 1'b1;
                                res_next = cde_pkg::make_result('0, cde_pkg::ST_EMPTY, '0,
                                                                count_reg, cap_reg);
                            end
                            else
                            begin
                                rd_en   = 1'b1;
                                rd_addr = q_op.left_end ? left_reg
                                                        : idx_prev(right_reg, cap_reg);
                            end
                        end
                        cde_pkg::OP_SEARCH:
                        begin
                            if (is_empty)
                            begin
                                load_out = 1'b1;
                                res_next = cde_pkg::make_result('0, cde_pkg::ST_NOT_FOUND, '0,
                                                                count_reg, cap_reg);
                            end
                            else
                            begin
                                // first read goes out now, compares start next cycle
                                rd_en     = 1'b1;
                                rd_addr   = left_reg;
                                addr_next = idx_next(left_reg, cap_reg);
                                pos_next  = '0;
                                key_next  = op_word;
                            end
                        end
                        cde_pkg::OP_CLEAR:
                        begin
                            left_next  = '0;
                            right_next = '0;
                            count_next = '0;
                            load_out   = 1'b1;
                            res_next   = cde_pkg::make_result('0, cde_pkg::ST_OK, '0,
                                                              '0, cap_reg);
                        end
                        default:
                        begin
                            load_out = 1'b0;
                        end
                    endcase
                end
            end
            cde_pkg::BK_READ:
            begin
                // read data holds until the result slot frees
                if (slot_free)
                begin
                    load_out = 1'b1;
                    res_next = cde_pkg::make_result(rd_word32, cde_pkg::ST_OK, '0,
                                                    count_reg, cap_reg);
                end
            end
            cde_pkg::BK_SEARCH:
            begin
                if (search_done)
                begin
                    if (slot_free)
                    begin
                        load_out = 1'b1;
                        if (hit)
                        begin
                            res_next = cde_pkg::make_result('0, cde_pkg::ST_OK,
                                                            pos_reg[cde_pkg::POS_W-1:0],
                                                            count_reg, cap_reg);
                        end
                        else
                        begin
                            res_next = cde_pkg::make_result('0, cde_pkg::ST_NOT_FOUND, '0,
                                                            count_reg, cap_reg);
                        end
                    end
                end
                else
                begin
                    // fetch the next entry toward the right end
                    rd_en     = 1'b1;
                    rd_addr   = addr_reg;
                    addr_next = idx_next(addr_reg, cap_reg);
                    pos_next  = pos_reg + 1'b1;
                end
            end
            default:
            begin
                load_out = 1'b0;
            end
        endcase
    end

    // Control registers; a capacity write also empties the deque
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cde_pkg::BK_IDLE;
            left_reg      <= '0;
            right_reg     <= '0;
            count_reg     <= '0;
            cap_reg       <= CAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                cap_reg   <= cap_cfg;
                left_reg  <= '0;
                right_reg <= '0;
                count_reg <= '0;
            end
            else
            begin
                left_reg  <= left_next;
                right_reg <= right_next;
                count_reg <= count_next;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        addr_reg <= addr_next;
        pos_reg  <= pos_next;
        if (load_out)
        begin
            res_reg <= res_next;
        end
    end

    // Ring store: one write or one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= op_word;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = res_reg;

`ifndef NO_ASSERTIONS
    // Count never exceeds the capacity in use
    a_count_le_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= cap_reg)
        else $error("entry count above capacity");

    // Both end indices stay inside the ring
    a_index_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
        (MW'(left_reg) < MW'(cap_reg)) && (MW'(right_reg) < MW'(cap_reg)))
        else $error("end index outside ring");

    // The store sees a read or a write in a cycle, never both
    a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
        !(rd_en && wr_en))
        else $error("read and write in same cycle");

    // Search offset stays below the count
    a_search_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cde_pkg::BK_SEARCH) |-> (pos_reg < count_reg))
        else $error("search past right end");

    // A result held for a read keeps its data while waiting for the slot
    a_read_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cde_pkg::BK_READ && !slot_free) |=> $stable(rd_data_reg))
        else $error("read data lost while stalled");
`endif

endmodule

### rtl/circular_deque_engine.sv
// Circular deque engine: push, clear and refused requests have their result word
// loaded when the back end takes them; pop and peek first pass a registered store
// read, and a search reads from the left end until a match or the right end.
// The back end takes one push or clear per cycle while the result slot is free;
// pop and peek (single registered store read port) and a search hold it until done.
// rst_n clears the deque, sets capacity min(DEPTH, 64); store contents not cleared.
`timescale 1ns / 1ps

module circular_deque_engine #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [6:0]          cfg_wr_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [2:0]          action,
    input  logic signed [31:0]  data_in,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [31:0]  data_out,
    output logic [1:0]          status,
    output logic [5:0]          found_position,
    output logic [6:0]          count_now,
    output logic                is_empty,
    output logic                is_full
);

    logic                q_push, q_full, q_valid, q_pop;
    cde_pkg::op_t        front_op, queue_op;
    cde_pkg::result_t    result;

    cde_front u_front (
        .in_valid (in_valid),
        .in_stall (in_stall),
        .action   (action),
        .data_in  (data_in),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_op     (front_op)
    );

    cde_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .op_in  (front_op),
        .full   (q_full),
        .valid  (q_valid),
        .pop    (q_pop),
        .op_out (queue_op)
    );

    cde_back #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_valid     (q_valid),
        .q_op        (queue_op),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result      (result)
    );

    // Result word onto separate ports
    assign data_out       = result.data;
    assign status         = result.status;
    assign found_position = result.pos;
    assign count_now      = result.count;
    assign is_empty       = result.empty;
    assign is_full        = result.full;

endmodule

### sim/circular_deque_engine_tb.sv
// Testbench for circular_deque_engine: directed and random request words under
// random idling on both sides, checked against a deque model in a scoreboard.
// Depends on cde_pkg (action, status and result types) and the engine RTL.
`timescale 1ns / 1ps

// Deque model plus the queue of result words it predicts
class deque_scoreboard;
    logic [31:0]       ring [64];
    int                left_ix;
    int                right_ix;
    int                entries;
    logic [6:0]        cap_reg;
    cde_pkg::result_t  expected_q [$];
    int                errors;

    function new();
        left_ix  = 0;
        right_ix = 0;
        entries  = 0;
        cap_reg  = 7'd64;
        errors   = 0;
    endfunction

    // A capacity write also empties the deque
    function void write_capacity(logic [6:0] value);
        cap_reg  = value;
        left_ix  = 0;
        right_ix = 0;
        entries  = 0;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    function int next_ix(int ix, int cap);
        return (ix + 1 >= cap) ? 0 : ix + 1;
    endfunction

    function int prev_ix(int ix, int cap);
        return (ix == 0 || ix > cap) ? cap - 1 : ix - 1;
    endfunction

    // Step the model for one accepted request word and queue its result
    function void note_input(cde_pkg::action_t act, logic [31:0] key);
        int               cap;
        cde_pkg::result_t r;
        cap      = (cap_reg == 7'd0) ? 1 : (cap_reg > 7'd64) ? 64 : int'(cap_reg);
        r.data   = '0;
        r.status = cde_pkg::ST_OK;
        r.pos    = '0;
        case (act)
            cde_pkg::ACT_PUSH_LEFT, cde_pkg::ACT_PUSH_RIGHT:
            begin
                if (entries >= cap)
                    r.status = cde_pkg::ST_FULL;
                else if (act == cde_pkg::ACT_PUSH_LEFT)
                begin
                    left_ix = prev_ix(left_ix, cap);
                    ring[left_ix] = key;
                    entries++;
                end
                else
                begin
                    ring[right_ix] = key;
                    right_ix = next_ix(right_ix, cap);
                    entries++;
                end
            end
            cde_pkg::ACT_POP_LEFT, cde_pkg::ACT_POP_RIGHT:
            begin
                if (entries == 0)
                    r.status = cde_pkg::ST_EMPTY;
                else if (act == cde_pkg::ACT_POP_LEFT)
                begin
                    r.data = ring[left_ix];
                    left_ix = next_ix(left_ix, cap);
                    entries--;
                end
                else
                begin
                    right_ix = prev_ix(right_ix, cap);
                    r.data = ring[right_ix];
                    entries--;
                end
            end
            cde_pkg::ACT_PEEK_LEFT, cde_pkg::ACT_PEEK_RIGHT:
            begin
                if (entries == 0)
                    r.status = cde_pkg::ST_EMPTY;
                else if (act == cde_pkg::ACT_PEEK_LEFT)
                    r.data = ring[left_ix];
                else
                    r.data = ring[prev_ix(right_ix, cap)];
            end
            cde_pkg::ACT_SEARCH:
            begin
                // first match from the left end wins
                r.status = cde_pkg::ST_NOT_FOUND;
                for (int i = 0; i < entries; i++)
                begin
                    if (r.status == cde_pkg::ST_NOT_FOUND &&
                        ring[(left_ix + i) % cap] == key)
                    begin
                        r.status = cde_pkg::ST_OK;
                        r.pos    = 6'(i);
                    end
                end
            end
            // clear
            default:
            begin
                left_ix  = 0;
                right_ix = 0;
                entries  = 0;
            end
        endcase
        r.count = 7'(entries);
        r.empty = (entries == 0);
        r.full  = (entries >= cap);
        expected_q.push_back(r);
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %h actual %h", $time, field, want, got);
            errors++;
        end
    endfunction

    // Compare one accepted result word with the oldest prediction
    function void check_result(logic [31:0] d, logic [1:0] st, logic [5:0] pos,
                               logic [6:0] cnt, logic emp, logic ful);
        cde_pkg::result_t r;
        if (expected_q.size() == 0)
        begin
            $display("%0t: result word with none expected, data_out %h status %0d",
                     $time, d, st);
            errors++;
            return;
        end
        r = expected_q.pop_front();
        compare_field("data_out", r.data, d);
        compare_field("status", 32'(r.status), 32'(st));
        compare_field("found_position", 32'(r.pos), 32'(pos));
        compare_field("count_now", 32'(r.count), 32'(cnt));
        compare_field("is_empty", 32'(r.empty), 32'(emp));
        compare_field("is_full", 32'(r.full), 32'(ful));
    endfunction
endclass

module circular_deque_engine_tb;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 80;
    localparam int NUM_PHASES   = 12;
    localparam int PHASE_WORDS  = 75;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [6:0]  cfg_wr_data;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  action;
    logic [31:0] data_in;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] data_out;
    logic [1:0]  status;
    logic [5:0]  found_position;
    logic [6:0]  count_now;
    logic        is_empty;
    logic        is_full;

    deque_scoreboard board;
    bit              in_idle_on;
    bit              out_idle_on;
    int              stall_left;
    int unsigned     cycle_count;
    logic [31:0]     key_pool [8];
    logic [6:0]      phase_caps [NUM_PHASES];

    circular_deque_engine dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .action         (action),
        .data_in        (data_in),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .data_out       (data_out),
        .status         (status),
        .found_position (found_position),
        .count_now      (count_now),
        .is_empty       (is_empty),
        .is_full        (is_full)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: timeout with %0d result words outstanding", $time, board.pending());
        $display("circular_deque_engine_tb NOT OK");
        $finish;
    end

    // Result side: check accepted words, stall in random bursts
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_result(data_out, status, found_position, count_now, is_empty, is_full);
        if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (out_idle_on && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 2);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // Present one request word, with an optional idle burst ahead of it
    task automatic send_word(cde_pkg::action_t act, logic [31:0] value);
        int gap;
        if (in_idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 3);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        data_in  <= value;
        do
            @(posedge clk);
        while (in_stall);
        board.note_input(act, value);
    endtask

    // Write capacity once the engine has drained
    task automatic set_capacity(logic [6:0] value);
        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        board.write_capacity(value);
    endtask

    function automatic cde_pkg::action_t pick_action(int push_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < push_pct)
            return $urandom_range(0, 1) ? cde_pkg::ACT_PUSH_RIGHT : cde_pkg::ACT_PUSH_LEFT;
        r = $urandom_range(0, 99);
        if (r < 40)
            return $urandom_range(0, 1) ? cde_pkg::ACT_POP_RIGHT : cde_pkg::ACT_POP_LEFT;
        if (r < 65)
            return $urandom_range(0, 1) ? cde_pkg::ACT_PEEK_RIGHT : cde_pkg::ACT_PEEK_LEFT;
        if (r < 95)
            return cde_pkg::ACT_SEARCH;
        return cde_pkg::ACT_CLEAR;
    endfunction

    // Mostly pool values so searches hit and duplicates occur
    function automatic logic [31:0] pick_word();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return key_pool[$urandom_range(0, 7)];
        if (r == 6)
            return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
        return $urandom;
    endfunction

    initial
    begin
        int                push_pct;
        cde_pkg::action_t  act;
        board       = new();
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = 7'd0;
        in_valid    = 1'b0;
        action      = cde_pkg::ACT_PUSH_LEFT;
        data_in     = 32'd0;
        out_stall   = 1'b0;
        stall_left  = 0;
        in_idle_on  = 1'b1;
        out_idle_on = 1'b1;
        phase_caps  = '{7'd1, 7'd2, 7'd64, 7'd3, 7'd65, 7'd7,
                        7'd64, 7'd0, 7'd127, 7'd33, 7'd64, 7'd5};
        phase_caps[9] = 7'($urandom_range(1, 64));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty refusals at reset capacity
        send_word(cde_pkg::ACT_POP_LEFT, 32'h0);
        send_word(cde_pkg::ACT_POP_RIGHT, 32'h0);
        send_word(cde_pkg::ACT_PEEK_LEFT, 32'h0);
        send_word(cde_pkg::ACT_PEEK_RIGHT, 32'h0);
        send_word(cde_pkg::ACT_SEARCH, 32'h0);
        // extremes at both ends, then peek, search, pop, clear and a peek when empty
        send_word(cde_pkg::ACT_PUSH_LEFT, 32'h8000_0000);
        send_word(cde_pkg::ACT_PUSH_RIGHT, 32'h7fff_ffff);
        send_word(cde_pkg::ACT_PUSH_LEFT, 32'hffff_ffff);
        send_word(cde_pkg::ACT_PUSH_RIGHT, 32'h0000_0000);
        send_word(cde_pkg::ACT_PEEK_LEFT, 32'h0);
        send_word(cde_pkg::ACT_PEEK_RIGHT, 32'h0);
        send_word(cde_pkg::ACT_SEARCH, 32'h7fff_ffff);
        send_word(cde_pkg::ACT_SEARCH, 32'h1234_5678);
        send_word(cde_pkg::ACT_POP_RIGHT, 32'h0);
        send_word(cde_pkg::ACT_POP_LEFT, 32'h0);
        send_word(cde_pkg::ACT_CLEAR, 32'h0);
        send_word(cde_pkg::ACT_PEEK_LEFT, 32'h0);
        // capacity zero acts as one: second push is refused as full
        set_capacity(7'd0);
        send_word(cde_pkg::ACT_PUSH_RIGHT, 32'h5555_5555);
        send_word(cde_pkg::ACT_PUSH_LEFT, 32'haaaa_aaaa);
        send_word(cde_pkg::ACT_SEARCH, 32'h5555_5555);
        send_word(cde_pkg::ACT_POP_LEFT, 32'h0);
        // capacity above the store depth acts as the depth; write on a busy deque
        set_capacity(7'd127);
        send_word(cde_pkg::ACT_PUSH_LEFT, 32'hdead_beef);
        send_word(cde_pkg::ACT_PUSH_LEFT, 32'h0bad_f00d);
        set_capacity(7'd64);
        send_word(cde_pkg::ACT_POP_RIGHT, 32'h0);

        // Random phases over a spread of capacities; no idling in the last two
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            for (int k = 0; k < 8; k++)
                key_pool[k] = $urandom;
            in_idle_on  = (p < NUM_PHASES - 2) && ($urandom_range(0, 3) != 0);
            out_idle_on = (p < NUM_PHASES - 2) && ($urandom_range(0, 3) != 0);
            set_capacity(phase_caps[p]);
            if (phase_caps[p] >= 7'd33)
                push_pct = (p % 2 == 0) ? 85 : 60;
            else
                push_pct = (p % 2 == 0) ? 70 : 35;
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                act = pick_action(push_pct);
                send_word(act, pick_word());
            end
        end

        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.errors == 0)
            $display("circular_deque_engine_tb OK");
        else
            $display("circular_deque_engine_tb NOT OK");
        $finish;
    end

endmodule
